// ===== rtl/lcdff_pkg.sv =====
// Shared types, constants and helper functions of the LCD field formatter.
// Depends on nothing; every other file of the block imports it.

package lcdff_pkg;

    // Largest decimal field, in digits.
    localparam int MAX_DIGITS = 5;

    // Input and magnitude widths follow the fixed field widths.
    localparam int VALUE_W  = 16;
    localparam int WIDTH_W  = 4;
    localparam int COLUMN_W = 6;
    localparam int MAG_W    = VALUE_W;

    // The converter takes two magnitude bits per cycle.
    localparam int CONV_STEPS = MAG_W / 2;
    localparam int CNT_W      = $clog2(CONV_STEPS);

    // Digit count, digit index and the width used for the range check.
    localparam int ND_W      = $clog2(MAX_DIGITS + 1);
    localparam int DIG_IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int CMP_W     = MAG_W + 4 * MAX_DIGITS;

    // Display codes.
    localparam logic [7:0] CHAR_ZERO     = 8'h30;
    localparam logic [7:0] CHAR_NINE     = 8'h39;
    localparam logic [7:0] CHAR_MINUS    = 8'h2d;
    localparam logic [7:0] CHAR_SPACE    = 8'h20;
    localparam logic [7:0] HEX_ALPHA_GAP = 8'h07;
    localparam logic [6:0] LINE2_OFFSET  = 7'h40;
    localparam logic       RS_COMMAND    = 1'b0;
    localparam logic       RS_DATA       = 1'b1;

    // Control of the digit chain for one cycle.
    typedef struct packed {
        logic load;   // clear the digits and take a new magnitude
        logic shift;  // run one two-bit conversion step
    } chain_ctrl_t;

    typedef logic [MAX_DIGITS-1:0][3:0] digit_row_t;

    // Ten to the power n, evaluated on constants only.
    function automatic logic [CMP_W-1:0] pow10(input int n);
        logic [CMP_W-1:0] p;
        p = CMP_W'(1);
        for (int i = 0; i < n; i++) begin
            p = CMP_W'(p * 10);
        end
        return p;
    endfunction

    // Uppercase ASCII character of one hex nibble.
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        c = CHAR_ZERO + {4'b0000, nib};
        if (c > CHAR_NINE) begin
            c = c + HEX_ALPHA_GAP;
        end
        return c;
    endfunction

endpackage

// ===== rtl/lcdff_bcd_cell.sv =====
// One decimal digit of the shift-and-add-3 converter chain.
// Depends on lcdff_pkg for the chain control struct.

module lcdff_bcd_cell
    import lcdff_pkg::*;
(
    input  logic        clk,
    input  chain_ctrl_t ctrl,
    input  logic [1:0]  bits_in,   // [1] enters first
    output logic [1:0]  bits_out,  // carries to the next higher digit
    output logic [3:0]  digit
);

    function automatic logic [3:0] adjust(input logic [3:0] d);
        return (d >= 4'd5) ? 4'(d + 4'd3) : d;
    endfunction

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adj_first;
    logic [3:0] adj_second;

    always_comb
    begin
        adj_first  = adjust(digit_reg);
        adj_second = adjust({adj_first[2:0], bits_in[1]});
        digit_next = {adj_second[2:0], bits_in[0]};
        bits_out   = {adj_first[3], adj_second[3]};
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load) begin
            digit_reg <= 4'd0;
        end else if (ctrl.shift) begin
            digit_reg <= digit_next;
        end
    end

    assign digit = digit_reg;

endmodule

// ===== rtl/lcdff_bcd_chain.sv =====
// Binary-to-BCD converter: a magnitude shift register feeding a row of digit cells.
// Depends on lcdff_pkg and lcdff_bcd_cell.

module lcdff_bcd_chain
    import lcdff_pkg::*;
(
    input  logic             clk,
    input  chain_ctrl_t      ctrl,
    input  logic [MAG_W-1:0] mag,
    output digit_row_t       digits
);

    logic [MAG_W-1:0] bin_reg;
    logic [1:0]       carry [MAX_DIGITS];

    always_ff @(posedge clk)
    begin
        if (ctrl.load) begin
            bin_reg <= mag;
        end else if (ctrl.shift) begin
            bin_reg <= {bin_reg[MAG_W-3:0], 2'b00};
        end
    end

    // The most significant bits enter the ones digit first.
    assign carry[0] = bin_reg[MAG_W-1 -: 2];

    for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_cell
        if (g < MAX_DIGITS - 1) begin : g_mid
            lcdff_bcd_cell u_cell (
                .clk      (clk),
                .ctrl     (ctrl),
                .bits_in  (carry[g]),
                .bits_out (carry[g+1]),
                .digit    (digits[g])
            );
        end else begin : g_top
            lcdff_bcd_cell u_cell (
                .clk      (clk),
                .ctrl     (ctrl),
                .bits_in  (carry[g]),
                .bits_out (),
                .digit    (digits[g])
            );
        end
    end

endmodule

// ===== rtl/lcd_field_formatter.sv =====
// Top level of the LCD field formatter: request sequencer, range check and output register.
// Depends on lcdff_pkg and lcdff_bcd_chain.
//
// Usage: each request on the s_ channel carries a number, a field width, a display line
// and a column. The block answers with a byte stream for an HD44780-style character
// display on the m_ channel: one set-address command, then in decimal mode an optional
// sign character and up to five zero-padded digits, or in hex mode two uppercase hex
// characters of the low byte. m_tlast marks the final byte of each request's run.
// A value that does not fit the field shows as all nines, with the overflow bit of
// m_tuser set on every byte of that run, the address command included.
// Throughput: one request at a time. A decimal request is accepted, then converted in the
// digit chain (two magnitude bits per cycle), then sent out as its run of bytes; a hex
// request skips the conversion. s_tready is high only while the block has no request in
// progress. When the receiver stalls, the output register holds its byte and the
// sequencer waits; nothing is dropped. Reset clears the sequencer and the output valid
// flag; the block is ready for a request in the first cycle after reset.

module lcd_field_formatter
    import lcdff_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // value[15:0], width[19:16], second_line[20],
                                   // column[26:21], zero[31:27]
    input  logic        s_tuser,   // action: 0 decimal, 1 hex
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // code[7:0]
    output logic [1:0]  m_tuser,   // register_select[0], overflow[1]
    output logic        m_tlast
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CONV  = 3'd1;
    localparam logic [2:0] ST_ADDR  = 3'd2;
    localparam logic [2:0] ST_SIGN  = 3'd3;
    localparam logic [2:0] ST_DIGIT = 3'd4;

    // Input fields.
    logic [VALUE_W-1:0]  in_value;
    logic [WIDTH_W-1:0]  in_width;
    logic                in_line2;
    logic [COLUMN_W-1:0] in_column;

    assign in_value  = s_tdata[15:0];
    assign in_width  = s_tdata[19:16];
    assign in_line2  = s_tdata[20];
    assign in_column = s_tdata[26:21];

    // Sequencer and request registers.
    logic [2:0]      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [ND_W-1:0] idx_reg, idx_next;
    logic            hex_reg;
    logic [6:0]      addr_reg;
    logic            sign_reg;
    logic            neg_reg;
    logic [ND_W-1:0] nd_reg;
    logic            sat_reg;
    logic [7:0]      byte_reg;

    // Output register.
    logic       out_valid_reg;
    logic [7:0] out_code_reg;
    logic       out_rs_reg;
    logic       out_ovf_reg;
    logic       out_last_reg;

    logic       accept;
    logic       out_free;
    logic       out_load;
    logic [7:0] load_code;
    logic       load_rs;
    logic       load_last;

    // Decode of the incoming request.
    logic               v_neg;
    logic               w_neg;
    logic [MAG_W-1:0]   mag;
    logic [WIDTH_W-1:0] w_abs;
    logic [ND_W-1:0]    nd;
    logic               sat;
    logic [CMP_W-1:0]   pow_tab [MAX_DIGITS+1];

    chain_ctrl_t chain_ctrl;
    digit_row_t  digits;
    logic [3:0]  cur_digit;

    for (genvar g = 0; g <= MAX_DIGITS; g++) begin : g_pow
        assign pow_tab[g] = pow10(g);
    end

    always_comb
    begin
        v_neg = in_value[VALUE_W-1];
        w_neg = in_width[WIDTH_W-1];
        mag   = v_neg ? MAG_W'(-in_value) : in_value;
        w_abs = w_neg ? WIDTH_W'(-in_width) : in_width;
        nd    = (w_abs > WIDTH_W'(MAX_DIGITS)) ? ND_W'(MAX_DIGITS) : ND_W'(w_abs);
        // A negative value without a sign position, or a magnitude of more than nd
        // digits, saturates a field of one digit or more.
        sat   = (nd != '0)
                && ((!w_neg && v_neg) || ({{(CMP_W-MAG_W){1'b0}}, mag} >= pow_tab[nd]));
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign chain_ctrl.load  = accept;
    assign chain_ctrl.shift = (state_reg == ST_CONV);

    lcdff_bcd_chain u_chain (
        .clk    (clk),
        .ctrl   (chain_ctrl),
        .mag    (mag),
        .digits (digits)
    );

    assign cur_digit = digits[idx_reg[DIG_IDX_W-1:0]];

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        out_load   = 1'b0;
        load_code  = {1'b1, addr_reg};
        load_rs    = RS_COMMAND;
        load_last  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (s_tvalid) begin
                    state_next = s_tuser ? ST_ADDR : ST_CONV;
                end
            end
            ST_CONV:
            begin
                cnt_next = CNT_W'(cnt_reg + 1'b1);
                if (cnt_reg == CNT_W'(CONV_STEPS - 1)) begin
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                out_load  = out_free;
                load_last = !hex_reg && (nd_reg == '0);
                if (out_free) begin
                    if (hex_reg) begin
                        state_next = ST_DIGIT;
                        idx_next   = ND_W'(1);
                    end else if (sign_reg) begin
                        state_next = ST_SIGN;
                    end else if (nd_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_DIGIT;
                        idx_next   = nd_reg - ND_W'(1);
                    end
                end
            end
            ST_SIGN:
            begin
                out_load  = out_free;
                load_rs   = RS_DATA;
                load_code = neg_reg ? CHAR_MINUS : CHAR_SPACE;
                if (out_free) begin
                    state_next = ST_DIGIT;
                    idx_next   = nd_reg - ND_W'(1);
                end
            end
            ST_DIGIT:
            begin
                out_load  = out_free;
                load_rs   = RS_DATA;
                load_last = (idx_reg == '0);
                if (hex_reg) begin
                    load_code = hex_char(idx_reg[0] ? byte_reg[7:4] : byte_reg[3:0]);
                end else if (sat_reg) begin
                    load_code = CHAR_NINE;
                end else begin
                    load_code = CHAR_ZERO + {4'b0000, cur_digit};
                end
                if (out_free) begin
                    if (idx_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next = idx_reg - ND_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request fields and output payload need no reset.
    always_ff @(posedge clk)
    begin
        if (accept) begin
            hex_reg  <= s_tuser;
            addr_reg <= {1'b0, in_column} + (in_line2 ? LINE2_OFFSET : 7'h00);
            sign_reg <= w_neg && !s_tuser;
            neg_reg  <= v_neg;
            nd_reg   <= nd;
            sat_reg  <= sat && !s_tuser;
            byte_reg <= in_value[7:0];
        end
        if (out_load) begin
            out_code_reg <= load_code;
            out_rs_reg   <= load_rs;
            out_ovf_reg  <= sat_reg;
            out_last_reg <= load_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_code_reg;
    assign m_tuser  = {out_ovf_reg, out_rs_reg};
    assign m_tlast  = out_last_reg;

    // A request that is taken closes the input until its run is over.
    a_accept_closes: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("input stayed open after a request was accepted");

    // Loading the final byte of a run returns the sequencer to idle.
    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && load_last |=> (state_reg == ST_IDLE))
        else $error("sequencer kept running after the final byte");

    // Hex runs never report overflow.
    a_hex_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && hex_reg |=> !m_tuser[1])
        else $error("overflow raised on a hex run");

    // Only the address command is sent as a command byte.
    a_cmd_is_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && (load_rs == RS_COMMAND) |-> (state_reg == ST_ADDR))
        else $error("command byte outside the address step");

endmodule
